// ===== src/tdq_pkg.sv =====
package tdq_pkg;

  // default sample format
  localparam int SAMPLE_WIDTH_DEF = 32;
  localparam int SAMPLE_FRAC_DEF  = 30;

  // configuration register indexes
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 64;
  localparam logic [CFG_IDX_W-1:0] CFG_OUTPUT_DEPTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DITHER_ENABLE = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_DITHER_SEED   = 2'd2;

  // xorshift64* generator
  localparam int GEN_W = 64;
  localparam logic [GEN_W-1:0] GEN_MULT   = 64'd2685821657736338717;
  localparam logic [GEN_W-1:0] SEED_RESET = 64'h9e3779b97f4a7c15;
  localparam int XS_A = 12;
  localparam int XS_B = 25;
  localparam int XS_C = 27;
  localparam int KEEP_SHIFT = 11;

  // dither fraction and output code format
  localparam int FRAC_BITS = 53;
  localparam int LSB16 = 15;
  localparam int LSB24 = 23;
  localparam int PCM_W = 24;

  // load enables for the two multiplier stages
  typedef struct packed {
    logic ld_a;
    logic ld_b;
  } mul_ctrl_t;

  // one xorshift step
  function automatic logic [GEN_W-1:0] xs_step(input logic [GEN_W-1:0] x);
    logic [GEN_W-1:0] t;
    t = x ^ (x >> XS_A);
    t = t ^ (t << XS_B);
    t = t ^ (t >> XS_C);
    return t;
  endfunction

endpackage

// ===== src/tdq_xorshift.sv =====
module tdq_xorshift import tdq_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             seed_we,
  input  logic [GEN_W-1:0] seed,
  input  logic             advance,
  output logic [GEN_W-1:0] x1,
  output logic [GEN_W-1:0] x2
);

  logic [GEN_W-1:0] state_r;

  // two chained steps per sample
  assign x1 = xs_step(state_r);
  assign x2 = xs_step(x1);

  // state: reload on seed write, advance twice per dithered sample
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= SEED_RESET | 64'd1;
    end else if (seed_we) begin
      state_r <= seed | 64'd1;
    end else if (advance) begin
      state_r <= x2;
    end
  end

endmodule

// ===== src/tdq_mul_hi53.sv =====
module tdq_mul_hi53 import tdq_pkg::*; (
  input  logic                       clk,
  input  mul_ctrl_t                  ctrl,
  input  logic [GEN_W-1:0]           x,
  output logic [GEN_W-KEEP_SHIFT-1:0] k
);

  localparam int HW = GEN_W / 2;
  localparam logic [HW-1:0] ML = GEN_MULT[HW-1:0];
  localparam logic [HW-1:0] MH = GEN_MULT[GEN_W-1:HW];

  logic [HW-1:0]    xl;
  logic [HW-1:0]    xh;
  logic [GEN_W-1:0] ll;
  logic [HW-1:0]    c1;
  logic [HW-1:0]    c2;
  logic [GEN_W-1:0] ll_r;
  logic [HW-1:0]    cr_r;
  logic [GEN_W-1:0] prod;
  logic [GEN_W-KEEP_SHIFT-1:0] k_r;

  // partial products: full low product, cross terms kept mod 2^32
  assign xl = x[HW-1:0];
  assign xh = x[GEN_W-1:HW];
  assign ll = GEN_W'(xl) * GEN_W'(ML);
  assign c1 = xh * ML;
  assign c2 = xl * MH;

  always_ff @(posedge clk) begin
    if (ctrl.ld_a) begin
      ll_r <= ll;
      cr_r <= c1 + c2;
    end
  end

  // combine and keep the top 53 bits of the low 64
  assign prod = ll_r + {cr_r, {HW{1'b0}}};

  always_ff @(posedge clk) begin
    if (ctrl.ld_b) begin
      k_r <= prod[GEN_W-1:KEEP_SHIFT];
    end
  end

  assign k = k_r;

endmodule

// ===== src/tdq_quant.sv =====
module tdq_quant import tdq_pkg::*; #(
  parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF,
  parameter int SAMPLE_FRAC  = SAMPLE_FRAC_DEF
) (
  input  logic signed [SAMPLE_WIDTH-1:0]   sample,
  input  logic [GEN_W-KEEP_SHIFT-1:0]      k1,
  input  logic [GEN_W-KEEP_SHIFT-1:0]      k2,
  input  logic                             depth24,
  input  logic                             dither_en,
  output logic signed [PCM_W-1:0]          pcm
);

  localparam int SH16 = FRAC_BITS + LSB16 - SAMPLE_FRAC;
  localparam int SH24 = FRAC_BITS + LSB24 - SAMPLE_FRAC;
  localparam int TW   = SAMPLE_WIDTH + SH24 + 2;
  localparam int QW   = TW - FRAC_BITS;

  logic signed [TW-1:0] s_ext;
  logic signed [TW-1:0] v;
  logic signed [TW-1:0] dk;
  logic signed [TW-1:0] total;
  logic signed [QW-1:0] q;
  logic signed [QW-1:0] hi;
  logic signed [QW-1:0] lo;
  logic signed [QW-1:0] qc;

  // sample scaled to units of 2^-53 of an output lsb
  assign s_ext = TW'(sample);
  assign v = depth24 ? (s_ext <<< SH24) : (s_ext <<< SH16);

  // triangular dither from the two uniforms
  assign dk = dither_en ? (TW'(k1) - TW'(k2)) : '0;

  // add half an lsb and floor
  assign total = v + (TW'(1) <<< (FRAC_BITS - 1)) + dk;
  assign q = total[TW-1:FRAC_BITS];

  // saturation to the two's-complement range of the selected depth
  assign hi = depth24 ? QW'((2 ** LSB24) - 1) : QW'((2 ** LSB16) - 1);
  assign lo = ~hi;
  assign qc = (q > hi) ? hi : ((q < lo) ? lo : q);
  assign pcm = qc[PCM_W-1:0];

endmodule

// ===== src/tpdf_dither_quantizer_core.sv =====
// a result passes the input register, both multiplier stages and the output register
// throughput: one sample per cycle unless stalled; the xorshift state steps twice and
//   the 64-bit products are built over two pipelined stages of 32x32 multipliers
// reset (synchronous, active low): pipeline emptied, 16-bit depth, dither off,
//   generator state loaded with 0x9e3779b97f4a7c15
module tpdf_dither_quantizer_core import tdq_pkg::*; #(
  parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF,
  parameter int SAMPLE_FRAC  = SAMPLE_FRAC_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic signed [SAMPLE_WIDTH-1:0] in_sample,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic signed [PCM_W-1:0]       out_pcm_code,
  input  logic                          cfg_we,
  input  logic [CFG_IDX_W-1:0]          cfg_index,
  input  logic [CFG_DATA_W-1:0]         cfg_wdata
);

  localparam int KW = GEN_W - KEEP_SHIFT;

  logic depth_r;
  logic dith_r;
  logic v1_r, v2_r, v3_r, v4_r;
  logic rdy1, rdy2, rdy3, rdy4;
  logic seed_we;
  logic advance;
  logic [GEN_W-1:0] x1, x2;
  logic [GEN_W-1:0] x1_s1_r, x2_s1_r;
  logic signed [SAMPLE_WIDTH-1:0] sample_s1_r, sample_s2_r, sample_s3_r;
  logic [KW-1:0] k1, k2;
  logic signed [PCM_W-1:0] pcm;
  logic signed [PCM_W-1:0] pcm_r;
  mul_ctrl_t mctl;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      depth_r <= 1'b0;
      dith_r  <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_OUTPUT_DEPTH:  depth_r <= cfg_wdata[0];
        CFG_DITHER_ENABLE: dith_r  <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  assign seed_we = cfg_we && (cfg_index == CFG_DITHER_SEED);

  // per-stage ready, bubbles collapse
  assign rdy4 = !v4_r || !out_stall;
  assign rdy3 = !v3_r || rdy4;
  assign rdy2 = !v2_r || rdy3;
  assign rdy1 = !v1_r || rdy2;
  assign in_stall = !rdy1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else begin
      if (rdy1) v1_r <= in_valid;
      if (rdy2) v2_r <= v1_r;
      if (rdy3) v3_r <= v2_r;
      if (rdy4) v4_r <= v3_r;
    end
  end

  // generator steps only for an accepted dithered request
  assign advance = in_valid && rdy1 && dith_r;

  tdq_xorshift u_gen (
    .clk     (clk),
    .rst_n   (rst_n),
    .seed_we (seed_we),
    .seed    (cfg_wdata),
    .advance (advance),
    .x1      (x1),
    .x2      (x2)
  );

  // input register and sample delay line
  always_ff @(posedge clk) begin
    if (rdy1) begin
      sample_s1_r <= in_sample;
      x1_s1_r     <= x1;
      x2_s1_r     <= x2;
    end
    if (rdy2) sample_s2_r <= sample_s1_r;
    if (rdy3) sample_s3_r <= sample_s2_r;
  end

  assign mctl.ld_a = rdy2;
  assign mctl.ld_b = rdy3;

  tdq_mul_hi53 u_mul1 (
    .clk  (clk),
    .ctrl (mctl),
    .x    (x1_s1_r),
    .k    (k1)
  );

  tdq_mul_hi53 u_mul2 (
    .clk  (clk),
    .ctrl (mctl),
    .x    (x2_s1_r),
    .k    (k2)
  );

  tdq_quant #(
    .SAMPLE_WIDTH (SAMPLE_WIDTH),
    .SAMPLE_FRAC  (SAMPLE_FRAC)
  ) u_quant (
    .sample    (sample_s3_r),
    .k1        (k1),
    .k2        (k2),
    .depth24   (depth_r),
    .dither_en (dith_r),
    .pcm       (pcm)
  );

  // output register
  always_ff @(posedge clk) begin
    if (rdy4) pcm_r <= pcm;
  end

  assign out_valid    = v4_r;
  assign out_pcm_code = pcm_r;

  // input only stalls when every stage is full and the output is held
  a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (v1_r && v2_r && v3_r && v4_r && out_stall))
    else $error("input stalled with room in the pipeline");

  // 16-bit depth keeps codes within the 16-bit range
  a_depth16: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !depth_r) |->
      ((out_pcm_code[PCM_W-1:LSB16] == '0) || (out_pcm_code[PCM_W-1:LSB16] == '1)))
    else $error("16-bit code out of range");

  // a blocked item in the last multiplier stage is neither lost nor altered
  a_s3_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (v3_r && !rdy4) |=> (v3_r && $stable(sample_s3_r) && $stable(k1) && $stable(k2)))
    else $error("stalled request changed in pipeline");

endmodule
